// ===== sv/ttceb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttceb_pkg
// Shared types, register indexes, reset values and the cosine entry function
// of the time-to-collision emergency brake.
// ----------------------------------------------------------------------------
package ttceb_pkg;

    localparam int unsigned IDX_W  = 11;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CFG_IW = 3;

    localparam logic [15:0]      RST_THRESHOLD   = 16'd1500;
    localparam logic [15:0]      RST_ANGLE_START = 16'hA000;
    localparam logic [15:0]      RST_ANGLE_STEP  = 16'd61;
    localparam logic [IDX_W-1:0] RST_WIN_FIRST   = 11'd360;
    localparam logic [IDX_W-1:0] RST_WIN_LAST    = 11'd720;

    // range * 1000, then scaled by Q15 one before the compare
    localparam logic signed [31:0] MS_PER_S = 32'sd1000;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IW-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_ANGLE_START = 3'd1,
        CFG_ANGLE_STEP  = 3'd2,
        CFG_WIN_FIRST   = 3'd3,
        CFG_WIN_LAST    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_SCALE,
        ST_RANGE,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] speed_mm_s;
        logic        [15:0] range_mm;
        logic               last_beam;
    } t_in_item;

    typedef struct packed {
        logic             brake;
        logic [IDX_W-1:0] first_hit_index;
    } t_out_item;

    // Quarter-wave cosine entry, Q15. Taylor series in Horner form on Q30;
    // only ever called with constant arguments to build the table.
    function automatic logic [15:0] cos_entry(input int unsigned k,
                                              input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] t;
        logic [63:0] c;
        logic [63:0] q;
        x  = (64'(k) * HALF_PI_Q30) >> tbits;
        x2 = (x * x) >> 30;
        h  = Q30_ONE - x2 / 64'd132;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd90;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd56;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd30;
        h  = Q30_ONE - ((x2 * h) >> 30) / 64'd12;
        t  = ((x2 * h) >> 30) >> 1;
        c  = (t < Q30_ONE) ? (Q30_ONE - t) : 64'd0;
        q  = (c + 64'd16384) >> 15;
        if (q > 64'd32768) begin
            q = 64'd32768;
        end
        return q[15:0];
    endfunction

endpackage

// ===== sv/ttceb_cos_rom.sv =====
// ----------------------------------------------------------------------------
// ttceb_cos_rom
// Folds a binary angle into the first quadrant and reads the quarter-wave
// cosine table; signed Q15 result is registered, valid in the cycle after the angle.
// ----------------------------------------------------------------------------
module ttceb_cos_rom
    import ttceb_pkg::*;
#(
    parameter int COS_TABLE_BITS = 8
) (
    input  logic               i_clk,
    input  logic        [15:0] i_angle,
    output logic signed [16:0] o_cos
);

    localparam int unsigned DEPTH = (1 << COS_TABLE_BITS) + 1;
    localparam int unsigned SHIFT = 14 - COS_TABLE_BITS;

    logic [15:0]               w_tab [DEPTH];
    logic [14:0]               w_fold;
    logic                      w_neg;
    logic [COS_TABLE_BITS:0]   w_k;
    logic [15:0]               r_entry;
    logic                      r_neg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_tab
        assign w_tab[k] = cos_entry(k, COS_TABLE_BITS);
    end

    always_comb begin
        case (i_angle[15:14])
            2'b00, 2'b10: w_fold = {1'b0, i_angle[13:0]};
            default:      w_fold = 15'd16384 - {1'b0, i_angle[13:0]};
        endcase
        w_neg = i_angle[15] ^ i_angle[14];
        w_k   = w_fold[14:SHIFT];
    end

    always_ff @(posedge i_clk) begin
        r_entry <= w_tab[w_k];
        r_neg   <= w_neg;
    end

    assign o_cos = r_neg ? -$signed({1'b0, r_entry}) : $signed({1'b0, r_entry});

endmodule

// ===== sv/ttc_emergency_brake_core.sv =====
// ----------------------------------------------------------------------------
// ttc_emergency_brake_core
// Time-to-collision emergency brake decision over one lidar scan.
//
// Input channel (valid/ready) takes odometry beats (mode 0), which load the
// forward speed in the idle cycle with no further work, and lidar beam beats
// (mode 1), one range each in beam order, the last marked by last_beam.
// A beam goes from acceptance to the next ready through the idle/accept state,
// three passes through one shared signed multiplier (speed*cos, threshold*rate,
// range*1000) and one compare/update state.
// Ready is high only in the idle state.
// Only the last beam of a scan yields a result beat (brake, first hit index),
// held in an output register until taken. A new beam may be accepted while
// it waits; a further last beam stalls in its compare cycle until the
// output register is free.
// Configuration is a plain write port; the user applies it only while the block is idle (unenforced).
// Reset (synchronous, active low) restores the register defaults, clears the
// speed and starts a fresh scan at angle_start; no output beat is pending.
// ----------------------------------------------------------------------------
module ttc_emergency_brake_core
    import ttceb_pkg::*;
#(
    parameter int MAX_BEAMS      = 2048,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int BEAM_CAP = (MAX_BEAMS > 2048) ? 2048 : MAX_BEAMS;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(BEAM_CAP - 1);

    t_state r_state, n_state;

    logic [15:0]        r_thr;
    logic [15:0]        r_ang_start;
    logic [15:0]        r_ang_step;
    logic [IDX_W-1:0]   r_win_first;
    logic [IDX_W-1:0]   r_win_last;

    logic signed [15:0] r_speed;
    logic [IDX_W-1:0]   r_beam_index;
    logic [15:0]        r_beam_angle;
    logic               r_hit_seen;
    logic [IDX_W-1:0]   r_hit_index;

    logic [15:0]        r_range;
    logic               r_last;
    logic signed [31:0] r_rate;
    logic [47:0]        r_rhs;
    logic [25:0]        r_lhs;

    logic               r_out_valid;
    t_out_item          r_out_item;

    logic signed [16:0] w_cos;
    logic signed [17:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [49:0] w_prod;
    logic               w_accept;
    logic               w_commit;
    logic               w_hit;
    logic               w_hit_seen;
    logic [IDX_W-1:0]   w_hit_index;

    ttceb_cos_rom #(
        .COS_TABLE_BITS(COS_TABLE_BITS)
    ) u_cos (
        .i_clk  (i_clk),
        .i_angle(r_beam_angle),
        .o_cos  (w_cos)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    // a last beam waits for the output register to free up
    assign w_commit   = (r_state == ST_DECIDE) && (!r_last || !r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept && i_in_item.mode) n_state = ST_RATE;
            ST_RATE:   n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_RANGE;
            ST_RANGE:  n_state = ST_DECIDE;
            ST_DECIDE: if (w_commit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_RATE: begin
                w_mul_a = 18'(r_speed);
                w_mul_b = 32'(w_cos);
            end
            ST_SCALE: begin
                w_mul_a = $signed({2'b00, r_thr});
                w_mul_b = r_rate;
            end
            ST_RANGE: begin
                w_mul_a = $signed({2'b00, r_range});
                w_mul_b = MS_PER_S;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // in-window beam with range*1000*32768 < threshold*rate, only for a closing rate
    assign w_hit = (r_beam_index >= r_win_first) && (r_beam_index <= r_win_last)
                   && (r_rate > 32'sd0) && (48'({r_lhs, 15'd0}) < r_rhs);
    assign w_hit_seen  = r_hit_seen || w_hit;
    assign w_hit_index = r_hit_seen ? r_hit_index : r_beam_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_thr        <= RST_THRESHOLD;
            r_ang_start  <= RST_ANGLE_START;
            r_ang_step   <= RST_ANGLE_STEP;
            r_win_first  <= RST_WIN_FIRST;
            r_win_last   <= RST_WIN_LAST;
            r_speed      <= '0;
            r_beam_index <= '0;
            r_beam_angle <= RST_ANGLE_START;
            r_hit_seen   <= 1'b0;
            r_hit_index  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD:   r_thr       <= i_cfg_data;
                    CFG_ANGLE_START: r_ang_start <= i_cfg_data;
                    CFG_ANGLE_STEP:  r_ang_step  <= i_cfg_data;
                    CFG_WIN_FIRST:   r_win_first <= i_cfg_data[IDX_W-1:0];
                    CFG_WIN_LAST:    r_win_last  <= i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept && !i_in_item.mode) begin
                r_speed <= i_in_item.speed_mm_s;
            end

            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_commit) begin
                if (r_last) begin
                    r_out_valid  <= 1'b1;
                    r_beam_index <= '0;
                    r_beam_angle <= r_ang_start;
                    r_hit_seen   <= 1'b0;
                    r_hit_index  <= '0;
                end else begin
                    if (r_beam_index < IDX_MAX) begin
                        r_beam_index <= r_beam_index + 1'b1;
                    end
                    r_beam_angle <= r_beam_angle + r_ang_step;
                    r_hit_seen   <= w_hit_seen;
                    r_hit_index  <= w_hit_index;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_range <= i_in_item.range_mm;
            r_last  <= i_in_item.last_beam;
        end
        if (r_state == ST_RATE) begin
            r_rate <= w_prod[31:0];
        end
        if (r_state == ST_SCALE) begin
            r_rhs <= w_prod[47:0];
        end
        if (r_state == ST_RANGE) begin
            r_lhs <= w_prod[25:0];
        end
        if (w_commit && r_last) begin
            r_out_item.brake           <= w_hit_seen;
            r_out_item.first_hit_index <= w_hit_seen ? w_hit_index : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== test/ttc_emergency_brake_core_tb.sv =====
// ----------------------------------------------------------------------------
// ttc_emergency_brake_core_tb
// Self-checking bench for the time-to-collision brake core. A queue-fed
// driver sends odometry and lidar beats with random gaps, the result side
// stalls at random, and a scan tracker with its own cosine table predicts
// every scan verdict, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module ttc_emergency_brake_core_tb;
    import ttceb_pkg::*;

    localparam int          LUT_BITS = 8;
    localparam logic [10:0] BEAM_CAP = 11'd2047;
    localparam logic [63:0] HORNER_DIV [4] = '{64'd90, 64'd56, 64'd30, 64'd12};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_item          in_item   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_item;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    t_in_item    beat_q[$];
    t_out_item   verdict_q[$];
    int          cos_tab [0:(1 << LUT_BITS)];
    int unsigned gap_left  = 0;
    int unsigned sink_left = 0;
    int          fault_cnt = 0;
    bit          idle_on   = 1'b0;

    // shadow registers and scan state
    logic [15:0]        thr_ms, ang_start, ang_step;
    logic [10:0]        win_lo, win_hi;
    logic signed [15:0] spd;
    logic [10:0]        beam_no, hit_no;
    logic [15:0]        beam_ang;
    bit                 hit_flag;

    ttc_emergency_brake_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Q15 cosine of k/2^LUT_BITS of a quarter turn, Taylor series on Q30
    function automatic int quarter_cos(int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] t;
        logic [63:0] c;
        logic [63:0] q;
        x  = (64'(k) * HALF_PI_Q30) >> LUT_BITS;
        x2 = (x * x) >> 30;
        h  = Q30_ONE - x2 / 64'd132;
        for (int i = 0; i < 4; i++) begin
            h = Q30_ONE - ((x2 * h) >> 30) / HORNER_DIV[i];
        end
        t = ((x2 * h) >> 30) / 64'd2;
        c = (t < Q30_ONE) ? (Q30_ONE - t) : 64'd0;
        q = (c + 64'd16384) >> 15;
        if (q > 64'd32768) begin
            q = 64'd32768;
        end
        return int'(q);
    endfunction

    function automatic int beam_cos(logic [15:0] ang);
        logic [15:0] f;
        bit          neg;
        case (ang[15:14])
            2'd0: begin
                f = ang;
                neg = 1'b0;
            end
            2'd1: begin
                f = 16'd32768 - ang;
                neg = 1'b1;
            end
            2'd2: begin
                f = ang - 16'd32768;
                neg = 1'b1;
            end
            default: begin
                f = 16'd0 - ang;
                neg = 1'b0;
            end
        endcase
        return neg ? -cos_tab[f >> (14 - LUT_BITS)] : cos_tab[f >> (14 - LUT_BITS)];
    endfunction

    function automatic void restart_scan();
        beam_no  = '0;
        beam_ang = ang_start;
        hit_flag = 1'b0;
        hit_no   = '0;
    endfunction

    // advance the scan by one accepted beat; a scan end queues its verdict
    function automatic void scan_step(t_in_item beat);
        longint    spd_l;
        longint    thr_l;
        longint    rng;
        longint    rate;
        bit        in_win;
        t_out_item res;
        if (beat.mode == 1'b0) begin
            spd = beat.speed_mm_s;
            return;
        end
        spd_l  = spd;
        thr_l  = thr_ms;
        rng    = beat.range_mm;
        rate   = spd_l * beam_cos(beam_ang);
        in_win = (beam_no >= win_lo) && (beam_no <= win_hi);
        if (in_win && rate > 0 && rng * 32768000 < thr_l * rate && !hit_flag) begin
            hit_flag = 1'b1;
            hit_no   = beam_no;
        end
        if (beat.last_beam) begin
            res.brake           = hit_flag;
            res.first_hit_index = hit_flag ? hit_no : '0;
            verdict_q = {verdict_q, res};
            restart_scan();
            return;
        end
        if (beam_no < BEAM_CAP) begin
            beam_no = beam_no + 11'd1;
        end
        beam_ang = beam_ang + ang_step;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                in_item  <= beat_q.pop_front();
                in_valid <= 1'b1;
                gap_left = pause_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        int unsigned span;
        if (sink_left != 0) begin
            sink_left = sink_left - 1;
        end else begin
            span = pause_len();
            if (span == 0 || !out_ready) begin
                out_ready <= 1'b1;
                sink_left = $urandom_range(0, 8);
            end else begin
                out_ready <= 1'b0;
                sink_left = span - 1;
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                scan_step(in_item);
            end
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no scan end pending");
                    fault_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_item.brake !== want.brake) begin
                        $error("brake: expected %0d, got %0d", want.brake, out_item.brake);
                        fault_cnt++;
                    end
                    if (out_item.first_hit_index !== want.first_hit_index) begin
                        $error("first_hit_index: expected %0d, got %0d",
                               want.first_hit_index, out_item.first_hit_index);
                        fault_cnt++;
                    end
                end
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_THRESHOLD:   thr_ms    = val;
            CFG_ANGLE_START: ang_start = val;
            CFG_ANGLE_STEP:  ang_step  = val;
            CFG_WIN_FIRST:   win_lo    = val[10:0];
            CFG_WIN_LAST:    win_hi    = val[10:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // unused fields carry noise
    task automatic queue_speed(logic [15:0] s);
        t_in_item b;
        b.mode       = 1'b0;
        b.speed_mm_s = s;
        b.range_mm   = 16'($urandom);
        b.last_beam  = 1'($urandom);
        beat_q = {beat_q, b};
    endtask

    task automatic queue_beam(logic [15:0] r, bit last);
        t_in_item b;
        b.mode       = 1'b1;
        b.speed_mm_s = 16'($urandom);
        b.range_mm   = r;
        b.last_beam  = last;
        beat_q = {beat_q, b};
    endtask

    // wait for the block to go quiet: nothing queued, nothing owed
    task automatic settle();
        do begin
            @(negedge clk);
        end while (beat_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (12) @(negedge clk);
    endtask

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int          rand_items;
        int          n_scans;
        int          len;
        int          obstacle;
        bit          open_tail;
        logic [15:0] v;
        logic [10:0] lo;

        for (int k = 0; k <= (1 << LUT_BITS); k++) begin
            cos_tab[k] = quarter_cos(k);
        end
        thr_ms    = RST_THRESHOLD;
        ang_start = RST_ANGLE_START;
        ang_step  = RST_ANGLE_STEP;
        win_lo    = RST_WIN_FIRST;
        win_hi    = RST_WIN_LAST;
        spd       = '0;
        restart_scan();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: one long open scan, angle wraps
        queue_speed(16'd2000);
        obstacle = $urandom_range(0, 1) ? $urandom_range(340, 740) : -1;
        for (int b = 0; b < 800; b++) begin
            queue_beam((b == obstacle) ? 16'($urandom_range(0, 2999))
                                       : 16'($urandom_range(3000, 65535)), 1'b0);
        end
        settle();

        // change window and limit mid-scan; first hit is the first beam after it unless the obstacle hit earlier
        cfg_write(CFG_WIN_FIRST, 16'hFB20);
        cfg_write(CFG_WIN_LAST, 16'h07FF);
        cfg_write(CFG_THRESHOLD, 16'hFFFF);
        cfg_write(CFG_ANGLE_START, 16'h0000);
        queue_speed(-16'sd5000);
        for (int b = 0; b < 5; b++) begin
            queue_beam(16'd0, b == 4);
        end
        settle();

        // directed: quadrants, speed extremes, zero limit, empty window
        idle_on = 1'b1;
        cfg_write(CFG_ANGLE_STEP, 16'd16384);
        cfg_write(CFG_WIN_FIRST, 16'd0);
        cfg_write(CFG_WIN_LAST, 16'd3);
        queue_speed(16'h7FFF);
        queue_beam(16'hFFFF, 1'b0);
        queue_beam(16'd0, 1'b0);
        queue_beam(16'd0, 1'b0);
        queue_beam(16'd0, 1'b1);
        queue_speed(16'h8000);
        for (int b = 0; b < 4; b++) begin
            queue_beam(16'd0, b == 3);
        end
        queue_speed(16'd0);
        queue_beam(16'd0, 1'b1);
        settle();
        cfg_write(CFG_THRESHOLD, 16'd0);
        queue_speed(16'h7FFF);
        queue_beam(16'd0, 1'b1);
        settle();
        cfg_write(CFG_THRESHOLD, 16'hFFFF);
        cfg_write(CFG_WIN_FIRST, 16'd5);
        cfg_write(CFG_WIN_LAST, 16'd4);
        for (int b = 0; b < 6; b++) begin
            queue_beam(16'd0, b == 5);
        end
        settle();

        rand_items = 0;
        while (rand_items < 820) begin
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 4))
                    0:       v = 16'd0;
                    1:       v = 16'hFFFF;
                    2:       v = 16'($urandom);
                    default: v = 16'($urandom_range(200, 6000));
                endcase
                cfg_write(CFG_THRESHOLD, v);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    default: v = 16'($urandom);
                endcase
                cfg_write(CFG_ANGLE_START, v);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       v = 16'd0;
                    1:       v = 16'hFFFF;
                    2:       v = 16'($urandom);
                    default: v = 16'($urandom_range(0, 2000));
                endcase
                cfg_write(CFG_ANGLE_STEP, v);
            end
            if ($urandom_range(0, 3) != 0) begin
                // upper data bits are noise, only 11 are kept
                case ($urandom_range(0, 7))
                    0: begin
                        lo = 11'($urandom_range(1, 12));
                        v  = {5'($urandom), lo - 11'd1};
                    end
                    1: begin
                        lo = 11'd0;
                        v  = {5'($urandom), 11'd2047};
                    end
                    default: begin
                        lo = 11'($urandom_range(0, 8));
                        v  = {5'($urandom), lo + 11'($urandom_range(0, 20))};
                    end
                endcase
                cfg_write(CFG_WIN_FIRST, {5'($urandom), lo});
                cfg_write(CFG_WIN_LAST, v);
            end

            n_scans   = $urandom_range(1, 6);
            open_tail = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < n_scans; s++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 12);
                if ($urandom_range(0, 1)) begin
                    queue_speed(($urandom_range(0, 9) < 7) ? 16'($urandom_range(500, 32767))
                                                           : 16'($urandom));
                    rand_items++;
                end
                for (int b = 0; b < len; b++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        queue_speed(16'($urandom));
                        rand_items++;
                    end
                    queue_beam(($urandom_range(0, 9) < 4) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3000)),
                               (b == len - 1) && !(open_tail && s == n_scans - 1));
                    rand_items++;
                end
            end
            settle();
        end

        settle();
        repeat (20) @(posedge clk);
        if (fault_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
